// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition and property checked in the same cycle.
`define ASSERT_SAME(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("same-cycle check failed");

// Property checked in the cycle after the condition.
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("next-cycle check failed");

`endif

// File: rtl/rclp_pkg.sv
`default_nettype none

package rclp_pkg;

   // Field widths
   localparam int CUTOFF_BITS = 24;
   localparam int STEP_BITS   = 20;
   localparam int SAMPLE_BITS = 32;

   // Smoothing factor arithmetic: n = fc * dt * 2pi, den = scale + n
   localparam int TWO_PI_BITS = 19;
   localparam int PROD1_BITS  = CUTOFF_BITS + STEP_BITS;
   localparam int NUM_BITS    = 63;
   localparam int DEN_BITS    = 64;
   localparam int REM_BITS    = DEN_BITS + 1;

   localparam logic [TWO_PI_BITS-1:0] TWO_PI_Q16 = 19'd411775;
   localparam logic [DEN_BITS-1:0]    TIME_SCALE = 64'd16777216000000;
   localparam logic [CUTOFF_BITS-1:0] CUTOFF_RESET = 24'd2560;

   // Item kinds on the request
   localparam logic KIND_SAMPLE  = 1'b0;
   localparam logic KIND_PRELOAD = 1'b1;

   // Result status
   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_BAD_STEP = 1'b1;

   // Operation codes passed from front to back
   localparam int OP_BITS = 2;
   localparam logic [OP_BITS-1:0] OP_PRELOAD = 2'd0;
   localparam logic [OP_BITS-1:0] OP_REJECT  = 2'd1;
   localparam logic [OP_BITS-1:0] OP_SAMPLE  = 2'd2;

   // Depth of the command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic                          kind;
      logic signed [SAMPLE_BITS-1:0] value;
      logic [STEP_BITS-1:0]          time_step;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] filtered;
      logic                          status;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/rclp_queue.sv
`default_nettype none

// Small command queue between front and back.
module rclp_queue #(
   parameter int WIDTH = 58
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             rd_en,
   output logic [WIDTH-1:0]      rd_data,
   output logic                  empty
);

   localparam int DEPTH    = rclp_pkg::QUEUE_DEPTH;
   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_wr, do_rd;

   assign full    = (count_ff == CNT_BITS'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = entry_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// File: rtl/rclp_front.sv
`default_nettype none

// Front end: takes a request beat, classifies it and works out the
// smoothing factor for samples with a restoring divider.
module rclp_front #(
   parameter int ALPHA_FRAC_BITS = 24
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  push,
   output logic                                       full,
   input  wire rclp_pkg::req_type                     req_data,
   input  wire logic [rclp_pkg::CUTOFF_BITS-1:0]      cutoff,
   input  wire logic                                  q_full,
   output logic                                       q_push,
   output logic [rclp_pkg::OP_BITS+rclp_pkg::SAMPLE_BITS+ALPHA_FRAC_BITS-1:0] q_data
);

   localparam int A        = ALPHA_FRAC_BITS;
   localparam int CNT_BITS = $clog2(A);

   localparam logic [2:0] F_IDLE = 3'd0;
   localparam logic [2:0] F_MUL1 = 3'd1;
   localparam logic [2:0] F_MUL2 = 3'd2;
   localparam logic [2:0] F_LOAD = 3'd3;
   localparam logic [2:0] F_DIV  = 3'd4;
   localparam logic [2:0] F_PUSH = 3'd5;

   logic [2:0]                                state_ff, state_in;
   logic [rclp_pkg::OP_BITS-1:0]              op_ff, op_in;
   logic signed [rclp_pkg::SAMPLE_BITS-1:0]   value_ff, value_in;
   logic [rclp_pkg::STEP_BITS-1:0]            dt_ff, dt_in;
   logic [rclp_pkg::PROD1_BITS-1:0]           prod1_ff, prod1_in;
   logic [rclp_pkg::REM_BITS-1:0]             rem_ff, rem_in;
   logic [rclp_pkg::DEN_BITS-1:0]             den_ff, den_in;
   logic [A-1:0]                              quo_ff, quo_in;
   logic [CNT_BITS-1:0]                       cnt_ff, cnt_in;
   logic [rclp_pkg::NUM_BITS-1:0]             num_prod;
   logic [rclp_pkg::REM_BITS-1:0]             shifted;
   logic [rclp_pkg::REM_BITS-1:0]             den_wide;

   assign full   = (state_ff != F_IDLE);
   assign q_push = (state_ff == F_PUSH) && !q_full;
   assign q_data = {op_ff, value_ff, quo_ff};

   // second multiply: fc * dt * 2pi
   assign num_prod = rclp_pkg::NUM_BITS'(prod1_ff)
                   * rclp_pkg::NUM_BITS'(rclp_pkg::TWO_PI_Q16);

   // one quotient bit per divider step
   assign shifted  = {rem_ff[rclp_pkg::REM_BITS-2:0], 1'b0};
   assign den_wide = {1'b0, den_ff};

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      value_in = value_ff;
      dt_in    = dt_ff;
      prod1_in = prod1_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (push) begin
               value_in = req_data.value;
               dt_in    = req_data.time_step;
               quo_in   = '0;
               if (req_data.kind == rclp_pkg::KIND_PRELOAD) begin
                  op_in    = rclp_pkg::OP_PRELOAD;
                  state_in = F_PUSH;
               end else if (req_data.time_step == '0) begin
                  op_in    = rclp_pkg::OP_REJECT;
                  state_in = F_PUSH;
               end else begin
                  op_in    = rclp_pkg::OP_SAMPLE;
                  state_in = F_MUL1;
               end
            end
         end
         F_MUL1: begin
            prod1_in = rclp_pkg::PROD1_BITS'(cutoff) * rclp_pkg::PROD1_BITS'(dt_ff);
            state_in = F_MUL2;
         end
         F_MUL2: begin
            rem_in   = rclp_pkg::REM_BITS'(num_prod);
            state_in = F_LOAD;
         end
         F_LOAD: begin
            den_in   = rclp_pkg::TIME_SCALE
                     + rclp_pkg::DEN_BITS'(rem_ff[rclp_pkg::NUM_BITS-1:0]);
            cnt_in   = '0;
            state_in = F_DIV;
         end
         F_DIV: begin
            if (shifted >= den_wide) begin
               rem_in = shifted - den_wide;
               quo_in = {quo_ff[A-2:0], 1'b1};
            end else begin
               rem_in = shifted;
               quo_in = {quo_ff[A-2:0], 1'b0};
            end
            if (cnt_ff == CNT_BITS'(A - 1)) begin
               state_in = F_PUSH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      value_ff <= value_in;
      dt_ff    <= dt_in;
      prod1_ff <= prod1_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      quo_ff   <= quo_in;
      cnt_ff   <= cnt_in;
   end

endmodule

`default_nettype wire

// File: rtl/rclp_back.sv
`default_nettype none

// Back end: holds the filter state, applies each command and keeps the
// result register on the response side.
module rclp_back #(
   parameter int ALPHA_FRAC_BITS = 24
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  q_empty,
   input  wire logic [rclp_pkg::OP_BITS+rclp_pkg::SAMPLE_BITS+ALPHA_FRAC_BITS-1:0] q_data,
   output logic                                       q_pop,
   output logic                                       empty,
   input  wire logic                                  pop,
   output rclp_pkg::rsp_type                          rsp_data
);

   localparam int A         = ALPHA_FRAC_BITS;
   localparam int S         = rclp_pkg::SAMPLE_BITS;
   localparam int MAG_BITS  = S + 1;
   localparam int LO_BITS   = MAG_BITS / 2;
   localparam int HI_BITS   = MAG_BITS - LO_BITS;
   localparam int PLO_BITS  = LO_BITS + A;
   localparam int PHI_BITS  = HI_BITS + A;
   localparam int PROD_BITS = MAG_BITS + A;

   localparam logic [2:0] B_IDLE  = 3'd0;
   localparam logic [2:0] B_ABS   = 3'd1;
   localparam logic [2:0] B_MLO   = 3'd2;
   localparam logic [2:0] B_MHI   = 3'd3;
   localparam logic [2:0] B_SUM   = 3'd4;
   localparam logic [2:0] B_APPLY = 3'd5;
   localparam logic [2:0] B_OUT   = 3'd6;

   logic [2:0]                   state_ff, state_in;
   logic [S-1:0]                 held_ff, held_in;
   logic                         primed_ff, primed_in;
   logic                         out_valid_ff, out_valid_in;
   logic [A-1:0]                 alpha_ff, alpha_in;
   logic [MAG_BITS-1:0]          diff_ff, diff_in;
   logic                         neg_ff, neg_in;
   logic [MAG_BITS-1:0]          mag_ff, mag_in;
   logic [PLO_BITS-1:0]          plo_ff, plo_in;
   logic [PHI_BITS-1:0]          phi_ff, phi_in;
   logic [MAG_BITS-1:0]          step_ff, step_in;
   rclp_pkg::rsp_type            res_ff, res_in;
   rclp_pkg::rsp_type            out_ff, out_in;

   logic [rclp_pkg::OP_BITS-1:0] q_op;
   logic [S-1:0]                 q_value;
   logic [A-1:0]                 q_alpha;
   logic [PROD_BITS-1:0]         prod_sum;
   logic [MAG_BITS-1:0]          held_wide;
   logic [MAG_BITS-1:0]          held_next;

   // command unpacking
   assign q_op    = q_data[A+S+rclp_pkg::OP_BITS-1 -: rclp_pkg::OP_BITS];
   assign q_value = q_data[A+S-1 -: S];
   assign q_alpha = q_data[A-1:0];

   assign q_pop    = (state_ff == B_IDLE) && !q_empty;
   assign empty    = !out_valid_ff;
   assign rsp_data = out_ff;

   // datapath helpers
   assign held_wide = {held_ff[S-1], held_ff};
   assign prod_sum  = PROD_BITS'(plo_ff) + (PROD_BITS'(phi_ff) << LO_BITS);
   assign held_next = neg_ff ? held_wide - step_ff : held_wide + step_ff;

   always_comb begin
      state_in     = state_ff;
      held_in      = held_ff;
      primed_in    = primed_ff;
      out_valid_in = out_valid_ff && !pop;
      alpha_in     = alpha_ff;
      diff_in      = diff_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      plo_in       = plo_ff;
      phi_in       = phi_ff;
      step_in      = step_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               alpha_in = q_alpha;
               state_in = B_OUT;
               unique case (q_op)
                  rclp_pkg::OP_PRELOAD: begin
                     held_in         = q_value;
                     primed_in       = 1'b1;
                     res_in.filtered = q_value;
                     res_in.status   = rclp_pkg::STATUS_OK;
                  end
                  rclp_pkg::OP_SAMPLE: begin
                     if (primed_ff) begin
                        diff_in  = {q_value[S-1], q_value} - held_wide;
                        state_in = B_ABS;
                     end else begin
                        // first sample passes straight through
                        held_in         = q_value;
                        primed_in       = 1'b1;
                        res_in.filtered = q_value;
                        res_in.status   = rclp_pkg::STATUS_OK;
                     end
                  end
                  default: begin
                     res_in.filtered = held_ff;
                     res_in.status   = rclp_pkg::STATUS_BAD_STEP;
                  end
               endcase
            end
         end
         B_ABS: begin
            neg_in   = diff_ff[MAG_BITS-1];
            mag_in   = diff_ff[MAG_BITS-1] ? -diff_ff : diff_ff;
            state_in = B_MLO;
         end
         B_MLO: begin
            plo_in   = PLO_BITS'(mag_ff[LO_BITS-1:0]) * PLO_BITS'(alpha_ff);
            state_in = B_MHI;
         end
         B_MHI: begin
            phi_in   = PHI_BITS'(mag_ff[MAG_BITS-1:LO_BITS]) * PHI_BITS'(alpha_ff);
            state_in = B_SUM;
         end
         B_SUM: begin
            step_in  = prod_sum[PROD_BITS-1:A];
            state_in = B_APPLY;
         end
         B_APPLY: begin
            held_in         = held_next[S-1:0];
            res_in.filtered = held_next[S-1:0];
            res_in.status   = rclp_pkg::STATUS_OK;
            state_in        = B_OUT;
         end
         B_OUT: begin
            // wait for the result register to free up
            if (!out_valid_ff || pop) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
               state_in     = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         held_ff      <= '0;
         primed_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         primed_ff    <= primed_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      alpha_ff <= alpha_in;
      diff_ff  <= diff_in;
      neg_ff   <= neg_in;
      mag_ff   <= mag_in;
      plo_ff   <= plo_in;
      phi_ff   <= phi_in;
      step_ff  <= step_in;
      res_ff   <= res_in;
      out_ff   <= out_in;
   end

endmodule

`default_nettype wire

// File: rtl/rc_low_pass_variable_step.sv
// Channel    Ports                     Beat taken when
// request    push, full, req_data      push && !full
// response   empty, pop, rsp_data      pop && !empty
// csr        csr_we, csr_wdata         csr_we (a zero cutoff is ignored)
//
// A sample with a nonzero step holds full through two multiply stages, a denominator
// add, one divider step per bit and the queue hand-off, which waits while the queue
// is full. Preload and rejected items go straight to the hand-off. The back works
// through its states per item and overlaps with the front via a 2-beat command queue.
// Reset (synchronous, active high) clears held output, primed flag, queue, result register,
// cutoff back to 10 Hz; a stalled response stops the back, then the front once the queue fills.
`default_nettype none

`include "assert_macros.svh"

module rc_low_pass_variable_step #(
   parameter int ALPHA_FRAC_BITS = 24
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             push,
   output logic                                  full,
   input  wire rclp_pkg::req_type                req_data,
   output logic                                  empty,
   input  wire logic                             pop,
   output rclp_pkg::rsp_type                     rsp_data,
   input  wire logic                             csr_we,
   input  wire logic [rclp_pkg::CUTOFF_BITS-1:0] csr_wdata
);

   localparam int ENTRY_BITS = rclp_pkg::OP_BITS + rclp_pkg::SAMPLE_BITS + ALPHA_FRAC_BITS;

   logic [rclp_pkg::CUTOFF_BITS-1:0] cutoff_ff, cutoff_in;
   logic                             q_push, q_full, q_pop, q_empty;
   logic [ENTRY_BITS-1:0]            q_wr_data, q_rd_data;

   // cutoff register; zero writes are dropped
   always_comb begin
      cutoff_in = cutoff_ff;
      if (csr_we && (csr_wdata != '0)) begin
         cutoff_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff <= rclp_pkg::CUTOFF_RESET;
      end else begin
         cutoff_ff <= cutoff_in;
      end
   end

   rclp_front #(
      .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .cutoff   (cutoff_ff),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_wr_data)
   );

   rclp_queue #(
      .WIDTH (ENTRY_BITS)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (q_wr_data),
      .full    (q_full),
      .rd_en   (q_pop),
      .rd_data (q_rd_data),
      .empty   (q_empty)
   );

   rclp_back #(
      .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_data   (q_rd_data),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   // checks
   `ASSERT_SAME(a_cutoff_nonzero, clock, reset, 1'b1, cutoff_ff != '0)
   `ASSERT_SAME(a_push_not_full, clock, reset, q_push, !q_full)
   `ASSERT_NEXT(a_push_fills, clock, reset, q_push, !q_empty)
   `ASSERT_NEXT(a_zero_cutoff_kept, clock, reset, csr_we && (csr_wdata == '0), $stable(cutoff_ff))

endmodule

`default_nettype wire

// File: verif/rclp_checker.sv
`default_nettype none

module rclp_checker #(
   parameter int ALPHA_FRAC_BITS = 24
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             push,
   input  wire logic                             full,
   input  wire rclp_pkg::req_type                req_data,
   input  wire logic                             empty,
   input  wire logic                             pop,
   input  wire rclp_pkg::rsp_type                rsp_data,
   input  wire logic                             csr_we,
   input  wire logic [rclp_pkg::CUTOFF_BITS-1:0] csr_wdata,
   output int                                    fail_count,
   output int                                    pending,
   output int                                    checked
);

   // Shadow state of the filter
   logic [rclp_pkg::CUTOFF_BITS-1:0]        model_cutoff;
   logic signed [rclp_pkg::SAMPLE_BITS-1:0] model_held;
   logic                                    model_primed;

   rclp_pkg::rsp_type expected_rsp[$];
   int                errors;
   int                compared;

   // Filter gain a: floor(n * 2^F / (scale + n)), n = fc * dt * 2pi
   function automatic logic [ALPHA_FRAC_BITS-1:0] calc_alpha(
      input logic [rclp_pkg::STEP_BITS-1:0] dt
   );
      logic [63:0]  n;
      logic [127:0] quot;
      n = 64'(model_cutoff) * 64'(dt) * 64'(rclp_pkg::TWO_PI_Q16);
      quot = (128'(n) << ALPHA_FRAC_BITS) / (128'(rclp_pkg::TIME_SCALE) + 128'(n));
      return quot[ALPHA_FRAC_BITS-1:0];
   endfunction

   // Apply one request beat to the shadow state and return the response
   function automatic rclp_pkg::rsp_type filter_step(input rclp_pkg::req_type item);
      rclp_pkg::rsp_type           res;
      logic [ALPHA_FRAC_BITS-1:0]  alpha;
      longint                      diff;
      logic [127:0]                mag;
      logic [127:0]                move;
      res.status = rclp_pkg::STATUS_OK;
      if (item.kind == rclp_pkg::KIND_PRELOAD) begin
         model_held   = item.value;
         model_primed = 1'b1;
      end else if (item.time_step == '0) begin
         res.status = rclp_pkg::STATUS_BAD_STEP;
      end else if (!model_primed) begin
         model_held   = item.value;
         model_primed = 1'b1;
      end else begin
         alpha = calc_alpha(item.time_step);
         diff  = longint'($signed(item.value)) - longint'(model_held);
         mag   = (diff < 0) ? 128'(-diff) : 128'(diff);
         // truncate toward zero so the output stays between old and input
         move  = (mag * 128'(alpha)) >> ALPHA_FRAC_BITS;
         if (diff < 0)
            model_held = model_held - rclp_pkg::SAMPLE_BITS'(move);
         else
            model_held = model_held + rclp_pkg::SAMPLE_BITS'(move);
      end
      res.filtered = model_held;
      return res;
   endfunction

   always @(posedge clock) begin
      rclp_pkg::rsp_type want;
      if (reset) begin
         model_cutoff = rclp_pkg::CUTOFF_RESET;
         model_held   = '0;
         model_primed = 1'b0;
         expected_rsp.delete();
      end else begin
         // a zero cutoff write is dropped by the block
         if (csr_we && csr_wdata != '0)
            model_cutoff = csr_wdata;

         // response beat against the oldest expectation
         if (pop && !empty) begin
            if (expected_rsp.size() == 0) begin
               $error("response beat with nothing expected: filtered %0d status %0d",
                      $signed(rsp_data.filtered), rsp_data.status);
               errors++;
            end else begin
               want = expected_rsp.pop_front();
               compared++;
               if (rsp_data.filtered !== want.filtered) begin
                  $error("filtered: expected %0d, actual %0d",
                         $signed(want.filtered), $signed(rsp_data.filtered));
                  errors++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
                  errors++;
               end
            end
         end

         // request beat
         if (push && !full)
            expected_rsp.push_back(filter_step(req_data));
      end
      fail_count <= errors;
      pending    <= expected_rsp.size();
      checked    <= compared;
   end

endmodule

`default_nettype wire

// File: verif/tb_top.sv
`default_nettype none

module tb_top;

   localparam int ALPHA_BITS  = 24;
   localparam int QUIET_LIMIT = 4000;
   localparam int CHUNK_ITEMS = 97;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             push = 1'b0;
   logic                             full;
   rclp_pkg::req_type                req_data = '0;
   logic                             empty;
   logic                             pop = 1'b0;
   rclp_pkg::rsp_type                rsp_data;
   logic                             csr_we = 1'b0;
   logic [rclp_pkg::CUTOFF_BITS-1:0] csr_wdata = '0;

   int fail_count;
   int pending;
   int checked;

   int send_idle_pct = 0;
   int take_idle_pct = 0;
   int sent_count    = 0;
   int preload_count = 0;
   int zero_count    = 0;
   int quiet_cycles  = 0;

   rc_low_pass_variable_step #(
      .ALPHA_FRAC_BITS (ALPHA_BITS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   rclp_checker #(
      .ALPHA_FRAC_BITS (ALPHA_BITS)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_data   (req_data),
      .empty      (empty),
      .pop        (pop),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Receiver: random back-pressure on the response side
   always @(posedge clock) begin
      pop <= ($urandom_range(99) >= take_idle_pct);
   end

   // Watchdog: cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no beat for %0d cycles, %0d responses outstanding",
                  quiet_cycles, pending);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic rclp_pkg::req_type mk(input logic kind, input logic [31:0] v,
                                            input logic [rclp_pkg::STEP_BITS-1:0] dt);
      rclp_pkg::req_type item;
      item.kind      = kind;
      item.value     = v;
      item.time_step = dt;
      return item;
   endfunction

   function automatic logic [31:0] rand_value();
      int unsigned pick;
      pick = $urandom_range(9);
      if (pick < 4)
         return $urandom();
      else if (pick < 8)
         return 32'(int'($urandom_range(2 ** 21)) - 2 ** 20);
      else begin
         case ($urandom_range(3))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
         endcase
      end
   endfunction

   function automatic logic [rclp_pkg::STEP_BITS-1:0] rand_step();
      int unsigned pick;
      pick = $urandom_range(9);
      if (pick < 5)
         return rclp_pkg::STEP_BITS'($urandom_range(1, 5000));
      else if (pick < 8)
         return rclp_pkg::STEP_BITS'($urandom_range(1, 100000));
      else if (pick < 9)
         return rclp_pkg::STEP_BITS'($urandom_range(1, 2 ** rclp_pkg::STEP_BITS - 1));
      else
         return '1;
   endfunction

   function automatic rclp_pkg::req_type rand_item();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 8)
         return mk(rclp_pkg::KIND_PRELOAD, rand_value(), rclp_pkg::STEP_BITS'($urandom()));
      else if (pick < 13)
         return mk(rclp_pkg::KIND_SAMPLE, rand_value(), '0);
      else
         return mk(rclp_pkg::KIND_SAMPLE, rand_value(), rand_step());
   endfunction

   // One request beat, with random idle cycles in front of it
   task automatic send_item(input rclp_pkg::req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (full);
      sent_count++;
      if (item.kind == rclp_pkg::KIND_PRELOAD)
         preload_count++;
      else if (item.time_step == '0)
         zero_count++;
   endtask

   // Wait until every response has come back
   task automatic drain();
      push <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_cutoff(input logic [rclp_pkg::CUTOFF_BITS-1:0] v);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      logic [rclp_pkg::CUTOFF_BITS-1:0] cutoffs[5];
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: unprimed reject, pass-through, primed reject, extremes
      send_item(mk(rclp_pkg::KIND_SAMPLE,  32'd12345,     '0));
      send_item(mk(rclp_pkg::KIND_SAMPLE,  32'h8000_0000, 20'd1));
      send_item(mk(rclp_pkg::KIND_SAMPLE,  32'h7FFF_FFFF, '0));
      send_item(mk(rclp_pkg::KIND_SAMPLE,  32'h7FFF_FFFF, '1));
      send_item(mk(rclp_pkg::KIND_SAMPLE,  32'h8000_0000, 20'd1));
      send_item(mk(rclp_pkg::KIND_SAMPLE,  32'h0000_0000, 20'd1000));
      send_item(mk(rclp_pkg::KIND_SAMPLE,  32'hFFFF_FFFF, 20'd50000));
      send_item(mk(rclp_pkg::KIND_PRELOAD, 32'h7FFF_FFFF, '0));
      send_item(mk(rclp_pkg::KIND_SAMPLE,  32'h7FFF_FFFF, 20'd777));
      send_item(mk(rclp_pkg::KIND_PRELOAD, 32'h8000_0000, '1));
      send_item(mk(rclp_pkg::KIND_SAMPLE,  32'h7FFF_FFFF, '1));
      send_item(mk(rclp_pkg::KIND_SAMPLE,  32'hFFFF_0000, 20'd20000));
      send_item(mk(rclp_pkg::KIND_PRELOAD, 32'h0000_0000, 20'd12345));
      send_item(mk(rclp_pkg::KIND_SAMPLE,  32'h0000_0001, 20'd1));
      send_item(mk(rclp_pkg::KIND_SAMPLE,  32'h5555_5555, 20'h55555));
      send_item(mk(rclp_pkg::KIND_SAMPLE,  32'hAAAA_AAAA, 20'hAAAAA));
      send_item(mk(rclp_pkg::KIND_SAMPLE,  32'hAAAA_AAAA, '0));

      // Random: three pressure phases, five cutoff writes each
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 14; take_idle_pct = 47; end
            1:       begin send_idle_pct = 47; take_idle_pct = 14; end
            default: begin send_idle_pct = 0;  take_idle_pct = 0;  end
         endcase
         // zero write must leave the previous cutoff in place
         cutoffs[0] = '0;
         cutoffs[1] = 24'd1;
         cutoffs[2] = '1;
         cutoffs[3] = rclp_pkg::CUTOFF_BITS'($urandom());
         cutoffs[4] = rclp_pkg::CUTOFF_BITS'($urandom_range(256, 65535));
         for (int c = 0; c < 5; c++) begin
            write_cutoff(cutoffs[c]);
            for (int i = 0; i < CHUNK_ITEMS; i++)
               send_item(rand_item());
         end
      end

      drain();
      repeat (40) @(posedge clock);

      $display("%0d request beats over three pressure phases and many cutoff settings",
               sent_count);
      $display("%0d responses compared; %0d preloads, %0d zero-step samples",
               checked, preload_count, zero_count);
      if (fail_count == 0 && pending == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire
